// File: hw/rtl/cdir_pkg.sv
// Shared types, constants and glyph helpers for the clock display renderer.
// No dependencies; imported by cdir_ctrl, cdir_dp and the top level.
package cdir_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;

    localparam int NUM_CHARS = 8;
    localparam int IDX_W     = 3;
    localparam int CODE_W    = 4;
    localparam int SECS_W    = 23;
    localparam int QUO_W     = 12;
    localparam int OFS_W     = 4;
    localparam int STEP_W    = 5;
    localparam int SHAMT_W   = 4;

    localparam logic [CODE_W-1:0] CODE_COLON   = 4'd10;
    localparam logic [CODE_W-1:0] CODE_INVALID = 4'd15;

    localparam logic [23:0] HOUR_DIV = 24'd3600;
    localparam logic [23:0] MIN_DIV  = 24'd60;
    // ceil(2^27 / 225) applied to seconds >> 4; ceil(2^18 / 60) for values below 3600
    localparam logic [19:0] HOUR_RECIP = 20'd596524;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;
    localparam logic [STEP_W-1:0] DIV_H_TOP = 5'd1;
    localparam logic [STEP_W-1:0] DIV_M_TOP = 5'd1;
    localparam logic [6:0] HOURS_MAX = 7'd99;

    localparam logic [3:0] PAGE_UPPER = 4'((PANEL_HEIGHT / 8 - 2) / 2);
    localparam logic [7:0] COL_BASE   = 8'((PANEL_WIDTH - NUM_CHARS * 12) / 2);

    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [3:0] LOW_MASK   = 4'hF;

    // Byte positions inside one page half of a redraw
    localparam logic [3:0] POS_PAGE   = 4'd0;
    localparam logic [3:0] POS_COL_LO = 4'd1;
    localparam logic [3:0] POS_COL_HI = 4'd2;
    localparam logic [3:0] POS_DATA   = 4'd3;
    localparam logic [STEP_W-1:0] HALF_BYTES = 5'd15;
    localparam logic [STEP_W-1:0] LAST_BYTE  = 5'd29;

    localparam logic [7:0] GLYPHS [0:10][0:4] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
        '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_H,
        OP_LATCH_H,
        OP_DIV_M,
        OP_DIGITS,
        OP_SELECT,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [SHAMT_W-1:0]  shamt;
        logic [STEP_W-1:0]   byte_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic has_diff;
        logic out_free;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_H,
        ST_LATCH_H,
        ST_DIV_M,
        ST_DIGITS,
        ST_COMPARE,
        ST_EMIT
    } ctrl_state_t;

    // Source column of a glyph; spacing column and unknown codes are blank
    function automatic logic [7:0] glyph_col(logic [CODE_W-1:0] code, logic [2:0] src);
        logic [7:0] col;
        col = 8'h00;
        if (code <= CODE_COLON && src < 3'd5) begin
            col = GLYPHS[code][src];
        end
        return col;
    endfunction

    // Each bit fills two pixel rows
    function automatic logic [7:0] expand4(logic [3:0] nib);
        logic [7:0] wide;
        for (int b = 0; b < 4; b++) begin
            wide[2*b]   = nib[b];
            wide[2*b+1] = nib[b];
        end
        return wide;
    endfunction

    // Tens digit of a value below 100, by reciprocal multiply
    function automatic logic [3:0] tens_of(logic [6:0] v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] units_of(logic [6:0] v);
        logic [6:0] t;
        t = {3'b000, tens_of(v)};
        return 4'(v - (t << 3) - (t << 1));
    endfunction

endpackage

// File: hw/rtl/clock_display_incremental_renderer.sv
// Top level of the incremental HH:MM:SS renderer for a page-addressed panel.
// Depends on cdir_pkg, cdir_ctrl and cdir_dp.
//
//  channel  direction  tdata / data               tuser / flag          tlast
//  s_       in         [22:0] total_seconds       invalidate            -
//  m_       out        [7:0]  out_byte            is_data               last byte of run
//  cfg_     in         [3:0]  column_offset       -                     -
//
// Each tick divides for hours and minutes in two steps each, quotient by reciprocal
// multiply then remainder, splits digits and compares; when a character is redrawn,
// 30 bytes then go through the single output register, paused by output stalls.
// Reset marks all eight cached characters invalid and clears column_offset.
// m_tready low holds the current byte and pauses emission; s_tready is high only
// while no tick is in work.
module clock_display_incremental_renderer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [22:0] total_seconds, [23] zero fill
    input  logic        s_tuser,   // [0] invalidate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] is_data
    output logic        m_tlast
);
    import cdir_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cdir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cdir_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .load_secs  (s_tdata[SECS_W-1:0]),
        .load_inval (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: hw/rtl/cdir_ctrl.sv
// Sequencer for the clock renderer: division steps, compare, byte emission.
// Depends on cdir_pkg; drives cdir_dp through a command struct.
module cdir_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cdir_pkg::dp_status_t status,
    output cdir_pkg::dp_cmd_t    cmd
);
    import cdir_pkg::*;

    ctrl_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIV_H;
                    step_next  = DIV_H_TOP;
                end
            end
            ST_DIV_H: begin
                step_next = step_reg - 5'd1;
                if (step_reg == '0) begin
                    state_next = ST_LATCH_H;
                end
            end
            ST_LATCH_H: begin
                state_next = ST_DIV_M;
                step_next  = DIV_M_TOP;
            end
            ST_DIV_M: begin
                step_next = step_reg - 5'd1;
                if (step_reg == '0) begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                step_next  = '0;
                state_next = status.has_diff ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    if (step_reg == LAST_BYTE) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.shamt    = step_reg[SHAMT_W-1:0];
        cmd.byte_idx = step_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_DIV_H:   cmd.op = OP_DIV_H;
            ST_LATCH_H: cmd.op = OP_LATCH_H;
            ST_DIV_M:   cmd.op = OP_DIV_M;
            ST_DIGITS:  cmd.op = OP_DIGITS;
            ST_COMPARE: begin
                if (status.has_diff) begin
                    cmd.op = OP_SELECT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op = OP_EMIT;
                end
            end
            default: begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

// File: hw/rtl/cdir_dp.sv
// Datapath: reciprocal-multiply dividers, digit split, character cache, byte
// builder, output register and column offset register. Depends on cdir_pkg.
module cdir_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cdir_pkg::dp_cmd_t                 cmd,
    output cdir_pkg::dp_status_t              status,
    input  logic [cdir_pkg::SECS_W-1:0]       load_secs,
    input  logic                              load_inval,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdir_pkg::OFS_W-1:0]        cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import cdir_pkg::*;

    logic [SECS_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [6:0]         hours_reg, hours_next;
    logic [CODE_W-1:0]  digit_reg [0:5];
    logic [CODE_W-1:0]  digit_next [0:5];
    logic [CODE_W-1:0]  cache_reg [0:NUM_CHARS-1];
    logic [CODE_W-1:0]  cache_next [0:NUM_CHARS-1];
    logic [IDX_W-1:0]   sel_idx_reg, sel_idx_next;
    logic [CODE_W-1:0]  sel_code_reg, sel_code_next;
    logic [OFS_W-1:0]   offset_reg, offset_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic [38:0]        hour_prod;
    logic [23:0]        hour_back;
    logic [24:0]        min_prod;
    logic [23:0]        min_back;
    logic [CODE_W-1:0]  target [0:NUM_CHARS-1];
    logic [NUM_CHARS-1:0] diff;
    logic [IDX_W-1:0]   first_idx;

    logic               lower;
    logic [3:0]         pos;
    logic [3:0]         data_pos;
    logic [3:0]         page;
    logic [7:0]         phys;
    logic [7:0]         col;
    logic [7:0]         gen_byte;
    logic               gen_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHARS; i++) begin
                cache_reg[i] <= CODE_INVALID;
            end
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_CHARS; i++) begin
                cache_reg[i] <= cache_next[i];
            end
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        hours_reg    <= hours_next;
        for (int i = 0; i < 6; i++) begin
            digit_reg[i] <= digit_next[i];
        end
        sel_idx_reg  <= sel_idx_next;
        sel_code_reg <= sel_code_next;
        out_byte_reg <= out_byte_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Two steps per division: quotient by reciprocal multiply, then remainder
    assign hour_prod = 39'(rem_reg[SECS_W-1:4]) * 39'(HOUR_RECIP);
    assign hour_back = 24'(quo_reg) * HOUR_DIV;
    assign min_prod  = 25'(rem_reg[11:0]) * 25'(MIN_RECIP);
    assign min_back  = 24'(quo_reg[5:0]) * MIN_DIV;

    always_comb begin
        target[0] = digit_reg[0];
        target[1] = digit_reg[1];
        target[2] = CODE_COLON;
        target[3] = digit_reg[2];
        target[4] = digit_reg[3];
        target[5] = CODE_COLON;
        target[6] = digit_reg[4];
        target[7] = digit_reg[5];
    end

    always_comb begin
        first_idx = '0;
        for (int i = 0; i < NUM_CHARS; i++) begin
            diff[i] = (target[i] != cache_reg[i]);
        end
        for (int i = NUM_CHARS - 1; i >= 0; i--) begin
            if (diff[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign status.has_diff = |diff;
    assign status.out_free = !out_valid_reg || m_tready;

    always_comb begin
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        hours_next    = hours_reg;
        sel_idx_next  = sel_idx_reg;
        sel_code_next = sel_code_reg;
        for (int i = 0; i < 6; i++) begin
            digit_next[i] = digit_reg[i];
        end
        for (int i = 0; i < NUM_CHARS; i++) begin
            cache_next[i] = cache_reg[i];
        end
        case (cmd.op)
            OP_LOAD: begin
                rem_next = load_secs;
                quo_next = '0;
                if (load_inval) begin
                    for (int i = 0; i < NUM_CHARS; i++) begin
                        cache_next[i] = CODE_INVALID;
                    end
                end
            end
            OP_DIV_H: begin
                if (cmd.shamt != '0) begin
                    quo_next = hour_prod[38:27];
                end else begin
                    rem_next = rem_reg - hour_back[SECS_W-1:0];
                end
            end
            OP_DIV_M: begin
                if (cmd.shamt != '0) begin
                    quo_next = QUO_W'(min_prod[24:18]);
                end else begin
                    rem_next = rem_reg - min_back[SECS_W-1:0];
                end
            end
            OP_LATCH_H: begin
                hours_next = (quo_reg > QUO_W'(HOURS_MAX)) ? HOURS_MAX : quo_reg[6:0];
                quo_next   = '0;
            end
            OP_DIGITS: begin
                digit_next[0] = tens_of(hours_reg);
                digit_next[1] = units_of(hours_reg);
                digit_next[2] = tens_of({1'b0, quo_reg[5:0]});
                digit_next[3] = units_of({1'b0, quo_reg[5:0]});
                digit_next[4] = tens_of({1'b0, rem_reg[5:0]});
                digit_next[5] = units_of({1'b0, rem_reg[5:0]});
            end
            OP_SELECT: begin
                sel_idx_next          = first_idx;
                sel_code_next         = target[first_idx];
                cache_next[first_idx] = target[first_idx];
            end
            default: begin
            end
        endcase
    end

    // Byte builder: three position commands then twelve columns per page
    assign lower    = (cmd.byte_idx >= HALF_BYTES);
    assign pos      = lower ? 4'(cmd.byte_idx - HALF_BYTES) : cmd.byte_idx[3:0];
    assign data_pos = pos - POS_DATA;
    assign page     = PAGE_UPPER + {3'b000, lower};
    assign phys     = COL_BASE + {2'b00, sel_idx_reg, 3'b000} + {3'b000, sel_idx_reg, 2'b00}
                      + {4'h0, offset_reg};
    assign col      = glyph_col(sel_code_reg, data_pos[3:1]);

    always_comb begin
        gen_data = 1'b0;
        case (pos)
            POS_PAGE:   gen_byte = CMD_PAGE | {4'h0, page};
            POS_COL_LO: gen_byte = {4'h0, phys[3:0] & LOW_MASK};
            POS_COL_HI: gen_byte = CMD_COL_HI | {4'h0, phys[7:4]};
            default: begin
                gen_byte = expand4(lower ? col[7:4] : col[3:0]);
                gen_data = 1'b1;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (cmd.op == OP_EMIT) begin
            out_valid_next = 1'b1;
            out_byte_next  = gen_byte;
            out_data_next  = gen_data;
            out_last_next  = (cmd.byte_idx == LAST_BYTE);
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign cfg_ready   = 1'b1;
    assign offset_next = cfg_valid ? cfg_data : offset_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
